FILE: rtl/core/packet_rate_pacer_queue_core_macros.svh
// assertion macros shared by the pacer queue checkers
// each macro expects clk and rst_n in the scope where it is used
`ifndef PACKET_RATE_PACER_QUEUE_CORE_MACROS_SVH
`define PACKET_RATE_PACER_QUEUE_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define PRPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition on the cycle after a trigger
`define PRPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/prpq_pkg.sv
// package for the packet rate pacer queue: widths, codes and beat types
// no dependencies; used by the interfaces, divider, core and checker
package prpq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int TIME_BITS     = 48;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W         = 16;
    localparam int TAG_W         = 16;
    localparam int TOTAL_W       = $clog2(QUEUE_DEPTH * 65535 + 1);
    localparam int QB_W          = 22;
    localparam int CFG_W         = 32;
    localparam int CFG_INDEX_W   = 1;
    localparam int BITS_PER_BYTE = 8;
    localparam int US_PER_SECOND = 1000000;
    // widest spacing numerator: max length times bits per byte times us per second
    localparam int NUM_W         = $clog2(65535 * 64'd8000000 + 1);
    localparam int DIV_CNT_W     = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RATE  = 1'd0,
        CFG_DELAY = 1'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLAMP,
        ST_WRITE,
        ST_DIV,
        ST_SETTLE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [LEN_W-1:0]     bytes;
        logic [TIME_BITS-1:0] enq_us;
        logic [TIME_BITS-1:0] rel_us;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                 accepted;
        logic                 popped_valid;
        logic [TAG_W-1:0]     popped_tag;
        logic [LEN_W-1:0]     popped_bytes;
        logic [TIME_BITS-1:0] popped_enqueue_us;
        logic [TIME_BITS-1:0] popped_release_us;
        logic                 head_valid;
        logic [TIME_BITS-1:0] head_release_us;
        logic [QB_W-1:0]      queued_bytes;
    } res_t;

    // request to the slot spacing divider
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } div_req_t;

    // answer of the slot spacing divider: rounded-up quotient
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/core/prpq_ifs.sv
// valid/ready channel interfaces for command and result beats
// depends on prpq_pkg
interface prpq_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [prpq_pkg::TIME_BITS-1:0] now_us;
    logic [prpq_pkg::LEN_W-1:0]     packet_bytes;
    logic [prpq_pkg::TAG_W-1:0]     packet_tag;

    modport source (output valid, cmd, now_us, packet_bytes, packet_tag, input ready);
    modport sink (input valid, cmd, now_us, packet_bytes, packet_tag, output ready);
endinterface

interface prpq_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic                           popped_valid;
    logic [prpq_pkg::TAG_W-1:0]     popped_tag;
    logic [prpq_pkg::LEN_W-1:0]     popped_bytes;
    logic [prpq_pkg::TIME_BITS-1:0] popped_enqueue_us;
    logic [prpq_pkg::TIME_BITS-1:0] popped_release_us;
    logic                           head_valid;
    logic [prpq_pkg::TIME_BITS-1:0] head_release_us;
    logic [prpq_pkg::QB_W-1:0]      queued_bytes;

    modport source (output valid, accepted, popped_valid, popped_tag, popped_bytes,
                    popped_enqueue_us, popped_release_us, head_valid,
                    head_release_us, queued_bytes, input ready);
    modport sink (input valid, accepted, popped_valid, popped_tag, popped_bytes,
                  popped_enqueue_us, popped_release_us, head_valid,
                  head_release_us, queued_bytes, output ready);
endinterface

FILE: rtl/core/prpq_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module prpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/prpq_div.sv
// bit-serial restoring divider, one quotient bit per cycle, rounds up
// depends on prpq_pkg
module prpq_div (
    input  logic                clk,
    input  logic                rst_n,
    input  prpq_pkg::div_req_t  req,
    output prpq_pkg::div_rsp_t  rsp
);

    logic                              run_reg;
    logic                              done_reg;
    logic [prpq_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [prpq_pkg::CFG_W-1:0]        rem_reg;
    logic [prpq_pkg::CFG_W-1:0]        rem_next;
    logic [prpq_pkg::NUM_W-1:0]        quo_reg;
    logic [prpq_pkg::CFG_W-1:0]        dvs_reg;
    logic [prpq_pkg::NUM_W-1:0]        result_reg;
    logic [prpq_pkg::CFG_W:0]          rem_sh;
    logic [prpq_pkg::CFG_W+1:0]        diff;
    logic                              ge;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[prpq_pkg::NUM_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
        ge       = !diff[prpq_pkg::CFG_W+1];
        rem_next = ge ? diff[prpq_pkg::CFG_W-1:0] : rem_sh[prpq_pkg::CFG_W-1:0];
    end

    // sequencing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= prpq_pkg::DIV_CNT_W'(prpq_pkg::NUM_W);
            end
            else if (run_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[prpq_pkg::NUM_W-2:0], ge};
            end
            else
            begin
                // round up when a remainder is left
                result_reg <= quo_reg + prpq_pkg::NUM_W'(rem_reg != '0);
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = result_reg;

endmodule

FILE: rtl/core/packet_rate_pacer_queue_core.sv
// Packet rate pacer queue. Command beats arrive on in_ch (enqueue, pop,
// clear, no-op); one result beat per command leaves on out_ch. The user
// must write registers on cfg_we/cfg_index/cfg_wdata only while idle (not
// enforced by the block): index 0 is the pacing rate in bit/s (zero releases
// at once), index 1 the signed delay bound in us (negative is unbounded).
// An enqueue gets a release time of max(now, next slot), capped at now plus
// the bound, and the next slot becomes that release time plus ceil(bits *
// 1e6 / rate) us. Pop, clear, no-op, empty and refused enqueues pass EXEC,
// SETTLE, REPORT; an unpaced enqueue adds WRITE, a paced one CLAMP, WRITE
// and DIV, where the bit-serial divider finds the spacing one quotient bit
// per cycle. The next command can be taken in the same cycle as the result.
// One command is in flight at a time; in_ch.ready is high only while idle.
// The result sits in an output register; if out_ch stalls, the next
// command is still taken and worked, then waits until the register frees.
// The 64-entry store is a RAM read at the head pointer; a pop before the
// head's release time releases nothing.
// Reset empties the queue, zeroes the slot and sets the rate to zero and
// the bound to unbounded. No clearing pass is needed.
// depends on prpq_pkg, prpq_ifs, prpq_ram, prpq_div
module packet_rate_pacer_queue_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [prpq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [prpq_pkg::CFG_W-1:0]         cfg_wdata,
    prpq_in_if.sink                            in_ch,
    prpq_out_if.source                         out_ch
);

    localparam logic [prpq_pkg::NUM_W-1:0] PACE_SCALE =
        prpq_pkg::NUM_W'(prpq_pkg::BITS_PER_BYTE * prpq_pkg::US_PER_SECOND);
    localparam logic [prpq_pkg::QB_W-1:0] QB_MAX = '1;

    function automatic logic [prpq_pkg::PTR_W-1:0] ptr_inc(
        input logic [prpq_pkg::PTR_W-1:0] p
    );
        logic [prpq_pkg::PTR_W-1:0] r;
        if (p == prpq_pkg::PTR_W'(prpq_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    prpq_pkg::state_t                   state_reg, state_next;
    prpq_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [prpq_pkg::TIME_BITS-1:0]     now_reg, now_next;
    logic [prpq_pkg::LEN_W-1:0]         bytes_reg, bytes_next;
    logic [prpq_pkg::TAG_W-1:0]         tag_reg, tag_next;
    logic [prpq_pkg::CFG_W-1:0]         rate_reg;
    logic [prpq_pkg::CFG_W-1:0]         delay_reg;
    logic [prpq_pkg::PTR_W-1:0]         head_reg, head_next;
    logic [prpq_pkg::PTR_W-1:0]         tail_reg, tail_next;
    logic [prpq_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [prpq_pkg::TOTAL_W-1:0]       total_reg, total_next;
    logic [prpq_pkg::TIME_BITS-1:0]     slot_reg, slot_next;
    logic [prpq_pkg::TIME_BITS-1:0]     rel_reg, rel_next;
    logic [prpq_pkg::TIME_BITS-1:0]     cap_reg, cap_next;
    logic [prpq_pkg::NUM_W-1:0]         prod_reg, prod_next;
    prpq_pkg::res_t                     work_reg, work_next;
    prpq_pkg::res_t                     out_reg, out_next;
    logic                               out_valid_reg, out_valid_next;

    logic                               ram_we;
    prpq_pkg::entry_t                   ram_wdata;
    logic [prpq_pkg::ENTRY_W-1:0]       ram_rdata;
    prpq_pkg::entry_t                   head_entry;
    prpq_pkg::div_req_t                 div_req;
    prpq_pkg::div_rsp_t                 div_rsp;

    logic [prpq_pkg::TIME_BITS-1:0]     bound;
    logic [prpq_pkg::TIME_BITS:0]       cap_sum;
    logic [prpq_pkg::TIME_BITS:0]       slot_sum;
    logic [prpq_pkg::TIME_BITS-1:0]     wait_us;
    logic [31:0]                        total_ext;

    // entry store, read continuously at the head pointer
    prpq_ram #(
        .WIDTH (prpq_pkg::ENTRY_W),
        .DEPTH (prpq_pkg::QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign head_entry = prpq_pkg::entry_t'(ram_rdata);

    // slot spacing divider
    prpq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // shared arithmetic terms
    always_comb
    begin
        bound     = prpq_pkg::TIME_BITS'(delay_reg[prpq_pkg::CFG_W-2:0]);
        cap_sum   = {1'b0, now_reg} + {1'b0, bound};
        slot_sum  = {1'b0, rel_reg} + (prpq_pkg::TIME_BITS + 1)'(div_rsp.quotient);
        wait_us   = rel_reg - now_reg;
        total_ext = 32'(total_reg);
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        bytes_next     = bytes_reg;
        tag_next       = tag_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        rel_next       = rel_reg;
        cap_next       = cap_reg;
        prod_next      = prod_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        ram_we         = 1'b0;
        ram_wdata      = '{tag: tag_reg, bytes: bytes_reg, enq_us: now_reg, rel_us: rel_reg};
        div_req        = '{start: 1'b0, dividend: prod_reg, divisor: rate_reg};

        case (state_reg)
            prpq_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next   = prpq_pkg::cmd_t'(in_ch.cmd);
                    now_next   = in_ch.now_us;
                    bytes_next = in_ch.packet_bytes;
                    tag_next   = in_ch.packet_tag;
                    state_next = prpq_pkg::ST_EXEC;
                end
            end

            prpq_pkg::ST_EXEC:
            begin
                work_next  = '0;
                state_next = prpq_pkg::ST_SETTLE;
                case (cmd_reg)
                    prpq_pkg::CMD_ENQ:
                    begin
                        if (bytes_reg == '0)
                        begin
                            work_next.accepted = 1'b1;
                        end
                        else if (count_reg != prpq_pkg::CNT_W'(prpq_pkg::QUEUE_DEPTH))
                        begin
                            work_next.accepted = 1'b1;
                            if (rate_reg != '0)
                            begin
                                rel_next   = (slot_reg > now_reg) ? slot_reg : now_reg;
                                cap_next   = cap_sum[prpq_pkg::TIME_BITS] ?
                                             '1 : cap_sum[prpq_pkg::TIME_BITS-1:0];
                                prod_next  = prpq_pkg::NUM_W'(bytes_reg) * PACE_SCALE;
                                state_next = prpq_pkg::ST_CLAMP;
                            end
                            else
                            begin
                                rel_next   = now_reg;
                                state_next = prpq_pkg::ST_WRITE;
                            end
                        end
                    end

                    prpq_pkg::CMD_POP:
                    begin
                        if (count_reg != '0 && head_entry.rel_us <= now_reg)
                        begin
                            work_next.popped_valid      = 1'b1;
                            work_next.popped_tag        = head_entry.tag;
                            work_next.popped_bytes      = head_entry.bytes;
                            work_next.popped_enqueue_us = head_entry.enq_us;
                            work_next.popped_release_us = head_entry.rel_us;
                            head_next  = ptr_inc(head_reg);
                            count_next = count_reg - 1'b1;
                            total_next = total_reg - prpq_pkg::TOTAL_W'(head_entry.bytes);
                        end
                    end

                    prpq_pkg::CMD_CLEAR:
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                        total_next = '0;
                        slot_next  = '0;
                    end

                    default:
                    begin
                        state_next = prpq_pkg::ST_SETTLE;
                    end
                endcase
            end

            // cap the wait at the delay bound
            prpq_pkg::ST_CLAMP:
            begin
                if (!delay_reg[prpq_pkg::CFG_W-1] && wait_us > bound)
                begin
                    rel_next = cap_reg;
                end
                state_next = prpq_pkg::ST_WRITE;
            end

            // store the entry at the tail
            prpq_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                tail_next  = ptr_inc(tail_reg);
                count_next = count_reg + 1'b1;
                total_next = total_reg + prpq_pkg::TOTAL_W'(bytes_reg);
                if (rate_reg != '0)
                begin
                    div_req.start = 1'b1;
                    state_next    = prpq_pkg::ST_DIV;
                end
                else
                begin
                    state_next = prpq_pkg::ST_SETTLE;
                end
            end

            // set the slot to the release time plus the rounded-up spacing
            prpq_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    slot_next  = slot_sum[prpq_pkg::TIME_BITS] ?
                                 '1 : slot_sum[prpq_pkg::TIME_BITS-1:0];
                    state_next = prpq_pkg::ST_SETTLE;
                end
            end

            // let the RAM read pick up the new head
            prpq_pkg::ST_SETTLE:
            begin
                state_next = prpq_pkg::ST_REPORT;
            end

            prpq_pkg::ST_REPORT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next                 = work_reg;
                    out_next.head_valid      = (count_reg != '0);
                    out_next.head_release_us = (count_reg != '0) ? head_entry.rel_us : '0;
                    out_next.queued_bytes    = (total_ext > 32'(QB_MAX)) ?
                                               QB_MAX : total_ext[prpq_pkg::QB_W-1:0];
                    out_valid_next           = 1'b1;
                    state_next               = prpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = prpq_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prpq_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= '0;
            delay_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (prpq_pkg::cfg_index_t'(cfg_index))
                prpq_pkg::CFG_RATE:  rate_reg  <= cfg_wdata;
                prpq_pkg::CFG_DELAY: delay_reg <= cfg_wdata;
                default:             rate_reg  <= rate_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        now_reg   <= now_next;
        bytes_reg <= bytes_next;
        tag_reg   <= tag_next;
        rel_reg   <= rel_next;
        cap_reg   <= cap_next;
        prod_reg  <= prod_next;
        work_reg  <= work_next;
        out_reg   <= out_next;
    end

    // channel outputs
    assign in_ch.ready              = (state_reg == prpq_pkg::ST_IDLE);
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.accepted          = out_reg.accepted;
    assign out_ch.popped_valid      = out_reg.popped_valid;
    assign out_ch.popped_tag        = out_reg.popped_tag;
    assign out_ch.popped_bytes      = out_reg.popped_bytes;
    assign out_ch.popped_enqueue_us = out_reg.popped_enqueue_us;
    assign out_ch.popped_release_us = out_reg.popped_release_us;
    assign out_ch.head_valid        = out_reg.head_valid;
    assign out_ch.head_release_us   = out_reg.head_release_us;
    assign out_ch.queued_bytes      = out_reg.queued_bytes;

endmodule

FILE: rtl/core/prpq_checker.sv
// port-level checks for the pacer queue core, bound to the top level
// depends on prpq_pkg and packet_rate_pacer_queue_core_macros.svh
`include "packet_rate_pacer_queue_core_macros.svh"

module prpq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           accepted,
    input logic                           popped_valid,
    input logic [prpq_pkg::TAG_W-1:0]     popped_tag,
    input logic [prpq_pkg::LEN_W-1:0]     popped_bytes,
    input logic [prpq_pkg::TIME_BITS-1:0] popped_enqueue_us,
    input logic [prpq_pkg::TIME_BITS-1:0] popped_release_us,
    input logic                           head_valid,
    input logic [prpq_pkg::TIME_BITS-1:0] head_release_us,
    input logic [prpq_pkg::QB_W-1:0]      queued_bytes
);

    logic out_stall;
    logic in_take;
    logic pop_fields_zero;
    logic head_fields_zero;

    // handshake and field summaries
    assign out_stall        = out_valid && !out_ready;
    assign in_take          = in_valid && in_ready;
    assign pop_fields_zero  = (popped_tag == '0) && (popped_bytes == '0) &&
                              (popped_enqueue_us == '0) && (popped_release_us == '0);
    assign head_fields_zero = (head_release_us == '0) && (queued_bytes == '0);

    // a result beat holds until taken
    `PRPQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(accepted), "beat not held")

    // one command at a time: no accept right after an accept
    `PRPQ_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready, "ready right after accept")

    // enqueue and release never in the same beat
    `PRPQ_ASSERT(a_enq_xor_pop, !(out_valid && accepted && popped_valid), "enq and pop both set")

    // no release means the released fields are zero
    `PRPQ_ASSERT(a_pop_zero, !(out_valid && !popped_valid) || pop_fields_zero, "stale pop fields")

    // empty queue reports no head and no bytes
    `PRPQ_ASSERT(a_empty_head, !(out_valid && !head_valid) || head_fields_zero, "empty queue not clean")

endmodule

bind packet_rate_pacer_queue_core prpq_checker u_prpq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .accepted          (out_ch.accepted),
    .popped_valid      (out_ch.popped_valid),
    .popped_tag        (out_ch.popped_tag),
    .popped_bytes      (out_ch.popped_bytes),
    .popped_enqueue_us (out_ch.popped_enqueue_us),
    .popped_release_us (out_ch.popped_release_us),
    .head_valid        (out_ch.head_valid),
    .head_release_us   (out_ch.head_release_us),
    .queued_bytes      (out_ch.queued_bytes)
);
